>>> hdl/oaie_pkg.sv
// ----------------------------------------------------------------------------
// Ordered array package
// Field widths, request codes, status codes and controller states.
// ----------------------------------------------------------------------------
package oaie_pkg;

   localparam int REQ_W  = 3;
   localparam int DATA_W = 32;
   localparam int IDX_W  = 6;
   localparam int CNT_W  = 6;
   localparam int ST_W   = 2;

   typedef enum logic [REQ_W-1:0] {
      OP_PUSH   = 3'd0,
      OP_POP    = 3'd1,
      OP_INSERT = 3'd2,
      OP_ERASE  = 3'd3,
      OP_DUMP   = 3'd4,
      OP_CLEAR  = 3'd5
   } op_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK         = 2'd0,
      ST_IGNORED    = 2'd1,
      ST_FULL       = 2'd2,
      ST_EMPTY_DUMP = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_INSERT,
      S_ERASE,
      S_DUMP
   } state_type;

endpackage

>>> hdl/oaie_if.sv
// ----------------------------------------------------------------------------
// Ordered array channel interfaces
// Valid/ready channels for requests and responses.
// ----------------------------------------------------------------------------
interface oaie_req_if;
   import oaie_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [REQ_W-1:0]         req_type;
   logic signed [DATA_W-1:0] value;
   logic [IDX_W-1:0]         index;

   modport source (output valid, output req_type, output value, output index, input ready);
   modport sink   (input valid, input req_type, input value, input index, output ready);
endinterface

interface oaie_rsp_if;
   import oaie_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [ST_W-1:0]          status;
   logic [CNT_W-1:0]         count;
   logic signed [DATA_W-1:0] elem_value;
   logic                     last;

   modport source (output valid, output status, output count, output elem_value,
                   output last, input ready);
   modport sink   (input valid, input status, input count, input elem_value,
                   input last, output ready);
endinterface

>>> hdl/ordered_array_insert_erase.sv
// ----------------------------------------------------------------------------
// Ordered array with insert and erase
// Fixed-capacity array of signed words held in a single-port-per-direction
// synchronous RAM, with push, pop, insert, erase, dump and clear requests.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  req_chan  in   valid/ready    req_type, value, index
//  rsp_chan  out  valid/ready    status, count, elem_value, last
//
//  Push, pop, clear and insert/erase at the tail finish without a shift.
//  Insert and erase at k shift the words from k to the tail; dump reads every
//  element from index 0 upwards, with one response per element.
//  Synchronous reset empties the array; RAM contents are not cleared.
//  A stalled response holds the dump walk; other requests wait for the slot.
// ----------------------------------------------------------------------------
module ordered_array_insert_erase #(
   parameter int DEPTH = 32
) (
   input logic        clock,
   input logic        reset,
   oaie_req_if.sink   req_chan,
   oaie_rsp_if.source rsp_chan
);
   import oaie_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = CNT_W + 1;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [AW-1:0]     ptr_ff, ptr_in;
   logic [AW-1:0]     end_ff, end_in;
   logic [AW-1:0]     key_ff, key_in;
   logic [AW-1:0]     wa_ff, wa_in;
   logic [DATA_W-1:0] val_ff, val_in;
   logic              more_ff, more_in;
   logic              pend_ff, pend_in;
   logic              last_ff, last_in;

   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic [DATA_W-1:0] rsp_elem_ff, rsp_elem_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              slot_free;
   logic              req_fire;
   logic              issue;
   logic [XW-1:0]     idx_x;
   logic [XW-1:0]     cnt_x;
   logic              full;
   logic              empty;

   logic              mem_we;
   logic              mem_re;
   logic [AW-1:0]     mem_wa;
   logic [AW-1:0]     mem_ra;
   logic [DATA_W-1:0] mem_wd;

   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE) && slot_free;
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign idx_x = XW'(req_chan.index);
   assign cnt_x = XW'(count_ff);
   assign full  = (cnt_x == XW'(DEPTH));
   assign empty = (count_ff == '0);

   // dump reads only when the previous element can move on
   assign issue = more_ff && ((state_ff != S_DUMP) || !pend_ff || slot_free);

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.count      = rsp_count_ff;
   assign rsp_chan.elem_value = rsp_elem_ff;
   assign rsp_chan.last       = rsp_last_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_chan.req_type)
                  OP_INSERT: begin
                     if ((idx_x < cnt_x) && !full) state_in = S_INSERT;
                  end
                  OP_ERASE: begin
                     if ((idx_x + 1'b1) < cnt_x) state_in = S_ERASE;
                  end
                  OP_DUMP: begin
                     if (!empty) state_in = S_DUMP;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_INSERT, S_ERASE: begin
            if (!more_ff && !pend_ff) state_in = S_IDLE;
         end
         S_DUMP: begin
            if (!more_ff && (!pend_ff || slot_free)) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and RAM control
   always_comb begin
      logic [XW-1:0] cnt_new_x;

      cnt_new_x     = XW'(count_ff);
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      end_in        = end_ff;
      key_in        = key_ff;
      wa_in         = wa_ff;
      val_in        = val_ff;
      more_in       = more_ff;
      pend_in       = pend_ff;
      last_in       = last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_elem_in   = rsp_elem_ff;
      rsp_last_in   = rsp_last_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_wa        = '0;
      mem_ra        = ptr_ff;
      mem_wd        = rd_data_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_elem_in   = '0;
               rsp_last_in   = 1'b1;
               key_in        = AW'(req_chan.index);
               val_in        = req_chan.value;
               case (req_chan.req_type)
                  OP_PUSH: begin
                     if (full) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        mem_we   = 1'b1;
                        mem_wa   = AW'(count_ff);
                        mem_wd   = req_chan.value;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_POP: begin
                     if (empty) rsp_status_in = ST_IGNORED;
                     else       count_in = count_ff - 1'b1;
                  end
                  OP_INSERT: begin
                     if (idx_x > cnt_x) begin
                        rsp_status_in = ST_IGNORED;
                     end else if (full) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        count_in = count_ff + 1'b1;
                        if (idx_x == cnt_x) begin
                           mem_we = 1'b1;
                           mem_wa = AW'(req_chan.index);
                           mem_wd = req_chan.value;
                        end else begin
                           ptr_in  = AW'(count_ff - 1'b1);
                           end_in  = AW'(req_chan.index);
                           more_in = 1'b1;
                           pend_in = 1'b0;
                        end
                     end
                  end
                  OP_ERASE: begin
                     if (idx_x >= cnt_x) begin
                        rsp_status_in = ST_IGNORED;
                     end else begin
                        count_in = count_ff - 1'b1;
                        ptr_in   = AW'(idx_x + 1'b1);
                        end_in   = AW'(count_ff - 1'b1);
                        more_in  = 1'b1;
                        pend_in  = 1'b0;
                     end
                  end
                  OP_DUMP: begin
                     if (empty) begin
                        rsp_status_in = ST_EMPTY_DUMP;
                     end else begin
                        rsp_valid_in = 1'b0;
                        ptr_in       = '0;
                        end_in       = AW'(count_ff - 1'b1);
                        more_in      = 1'b1;
                        pend_in      = 1'b0;
                     end
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  default: rsp_status_in = ST_IGNORED;
               endcase
               cnt_new_x    = XW'(count_in);
               rsp_count_in = cnt_new_x[CNT_W-1:0];
            end
         end
         S_INSERT: begin
            // read downwards, write each word one place up
            pend_in = issue;
            if (issue) begin
               mem_re = 1'b1;
               wa_in  = ptr_ff + 1'b1;
               if (ptr_ff == end_ff) more_in = 1'b0;
               else                  ptr_in  = ptr_ff - 1'b1;
            end
            if (pend_ff) begin
               mem_we = 1'b1;
               mem_wa = wa_ff;
            end else if (!more_ff) begin
               mem_we = 1'b1;
               mem_wa = key_ff;
               mem_wd = val_ff;
            end
         end
         S_ERASE: begin
            // read upwards, write each word one place down
            pend_in = issue;
            if (issue) begin
               mem_re = 1'b1;
               wa_in  = ptr_ff - 1'b1;
               if (ptr_ff == end_ff) more_in = 1'b0;
               else                  ptr_in  = ptr_ff + 1'b1;
            end
            if (pend_ff) begin
               mem_we = 1'b1;
               mem_wa = wa_ff;
            end
         end
         S_DUMP: begin
            if (pend_ff && slot_free) begin
               cnt_new_x     = XW'(count_ff);
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_count_in  = cnt_new_x[CNT_W-1:0];
               rsp_elem_in   = rd_data_ff;
               rsp_last_in   = last_ff;
            end
            if (issue) begin
               mem_re  = 1'b1;
               pend_in = 1'b1;
               last_in = (ptr_ff == end_ff);
               if (ptr_ff == end_ff) more_in = 1'b0;
               else                  ptr_in  = ptr_ff + 1'b1;
            end else if (slot_free) begin
               pend_in = 1'b0;
            end
         end
         default: begin
            more_in = 1'b0;
            pend_in = 1'b0;
         end
      endcase
   end

   // element RAM, registered read
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      if (mem_re) rd_data_ff <= mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         more_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         more_ff      <= more_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff        <= ptr_in;
      end_ff        <= end_in;
      key_ff        <= key_in;
      wa_ff         <= wa_in;
      val_ff        <= val_in;
      last_ff       <= last_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_elem_ff   <= rsp_elem_in;
      rsp_last_ff   <= rsp_last_in;
   end

endmodule

>>> hdl/oaie_checker.sv
// ----------------------------------------------------------------------------
// Ordered array port checker
// Checks response consistency seen on the top-level ports.
// ----------------------------------------------------------------------------
module oaie_checker #(
   parameter int DEPTH = 32
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [oaie_pkg::ST_W-1:0]         rsp_status,
   input logic [oaie_pkg::CNT_W-1:0]        rsp_count,
   input logic signed [oaie_pkg::DATA_W-1:0] rsp_elem_value,
   input logic                              rsp_last
);
   import oaie_pkg::*;

   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid straight after reset");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (DEPTH >= 64) || ((CNT_W+1)'(rsp_count) <= (CNT_W+1)'(DEPTH)))
      else $error("response count beyond capacity");

   a_empty_dump: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_EMPTY_DUMP)) |-> (rsp_count == '0) && rsp_last)
      else $error("empty dump response with non-zero count or not last");

   a_non_ok_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_OK)) |-> rsp_last && (rsp_elem_value == '0))
      else $error("rejected request response not single or carries data");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_count) && $stable(rsp_elem_value) && $stable(rsp_last))
      else $error("stalled response changed");

endmodule

bind ordered_array_insert_erase oaie_checker #(.DEPTH(DEPTH)) u_oaie_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_status     (rsp_chan.status),
   .rsp_count      (rsp_chan.count),
   .rsp_elem_value (rsp_chan.elem_value),
   .rsp_last       (rsp_chan.last)
);

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered array testbench
// Sends push, pop, insert, erase, dump and clear requests in bursts with
// random gaps while the response side stalls on its own pattern. A shadow
// copy of the array, updated as each request is accepted, gives the expected
// responses, which are checked in order as they arrive.
// ----------------------------------------------------------------------------
module tb;
   import oaie_pkg::*;

   localparam int DEPTH    = 32;
   localparam int LIMIT_NS = 4_000_000;

   localparam logic [REQ_W-1:0]         OP_SPARE_6 = 3'd6;
   localparam logic [REQ_W-1:0]         OP_SPARE_7 = 3'd7;
   localparam logic signed [DATA_W-1:0] WORD_MIN   = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] WORD_MAX   = 32'sh7fff_ffff;

   typedef enum int {PH_GROW, PH_SHRINK, PH_MIXED} mix_phase_type;

   typedef struct {
      status_type               status;
      logic [CNT_W-1:0]         count;
      logic signed [DATA_W-1:0] elem_value;
      logic                     last;
   } array_rsp_type;

   logic clock;
   logic reset;

   oaie_req_if req_if ();
   oaie_rsp_if rsp_if ();

   ordered_array_insert_erase #(
      .DEPTH (DEPTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if.sink),
      .rsp_chan (rsp_if.source)
   );

   logic signed [DATA_W-1:0] shadow_store [DEPTH];
   int                       shadow_count = 0;
   array_rsp_type            expected_rsps [$];
   int                       error_count  = 0;
   bit                       gaps_on      = 1'b1;
   int                       burst_left   = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #(LIMIT_NS);
      $display("*** FAILED ***");
      $finish;
   end

   // response stall pattern: free running, short stalls or long stalls
   initial begin : rsp_sink
      int stall_left;
      int mode_left;
      int sink_mode;
      stall_left = 0;
      mode_left  = 0;
      sink_mode  = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (mode_left == 0) begin
            sink_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(32, 160);
         end else begin
            mode_left--;
         end
         if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_if.ready <= 1'b1;
            if (sink_mode == 1 && $urandom_range(0, 3) == 0) begin
               stall_left = $urandom_range(1, 3);
            end else if (sink_mode == 2 && $urandom_range(0, 7) == 0) begin
               stall_left = $urandom_range(4, 8);
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      array_rsp_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (expected_rsps.size() == 0) begin
            $error("unexpected response: status %0d count %0d", rsp_if.status, rsp_if.count);
            error_count++;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_if.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_if.status);
               error_count++;
            end
            if (rsp_if.count !== want.count) begin
               $error("count: expected %0d, actual %0d", want.count, rsp_if.count);
               error_count++;
            end
            if (rsp_if.elem_value !== want.elem_value) begin
               $error("elem_value: expected %0d, actual %0d", want.elem_value,
                      rsp_if.elem_value);
               error_count++;
            end
            if (rsp_if.last !== want.last) begin
               $error("last: expected %0d, actual %0d", want.last, rsp_if.last);
               error_count++;
            end
         end
      end
   end

   function automatic void predict_array_rsp(input logic [REQ_W-1:0] op,
                                             input logic signed [DATA_W-1:0] val,
                                             input logic [IDX_W-1:0] idx);
      status_type st;
      int         pos;
      pos = int'(idx);
      st  = ST_OK;
      case (op)
         OP_PUSH: begin
            if (shadow_count >= DEPTH) begin
               st = ST_FULL;
            end else begin
               shadow_store[shadow_count] = val;
               shadow_count++;
            end
         end
         OP_POP: begin
            if (shadow_count == 0) st = ST_IGNORED;
            else shadow_count--;
         end
         OP_INSERT: begin
            if (pos > shadow_count) begin
               st = ST_IGNORED;
            end else if (shadow_count >= DEPTH) begin
               st = ST_FULL;
            end else begin
               for (int k = shadow_count; k > pos; k--) shadow_store[k] = shadow_store[k-1];
               shadow_store[pos] = val;
               shadow_count++;
            end
         end
         OP_ERASE: begin
            if (pos >= shadow_count) begin
               st = ST_IGNORED;
            end else begin
               shadow_count--;
               for (int k = pos; k < shadow_count; k++) shadow_store[k] = shadow_store[k+1];
            end
         end
         OP_DUMP: begin
            if (shadow_count == 0) begin
               expected_rsps.push_back(array_rsp_type'{ST_EMPTY_DUMP, '0, '0, 1'b1});
            end else begin
               for (int k = 0; k < shadow_count; k++) begin
                  expected_rsps.push_back(array_rsp_type'{ST_OK, CNT_W'(shadow_count),
                                                          shadow_store[k],
                                                          k == shadow_count - 1});
               end
            end
            return;
         end
         OP_CLEAR: shadow_count = 0;
         default:  st = ST_IGNORED;
      endcase
      expected_rsps.push_back(array_rsp_type'{st, CNT_W'(shadow_count), '0, 1'b1});
   endfunction

   task automatic send_request(input logic [REQ_W-1:0] op,
                               input logic signed [DATA_W-1:0] val,
                               input logic [IDX_W-1:0] idx);
      int gap;
      gap = 0;
      if (gaps_on) begin
         if (burst_left == 0) begin
            gap        = $urandom_range(1, 8);
            burst_left = $urandom_range(1, 12);
         end else begin
            burst_left--;
         end
      end
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.req_type <= op;
      req_if.value    <= val;
      req_if.index    <= idx;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      predict_array_rsp(op, val, idx);
   endtask

   task automatic drain_responses();
      req_if.valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (DEPTH + 4) @(posedge clock);
   endtask

   task automatic test_directed_edges();
      send_request(OP_DUMP,   '0,       6'd0);
      send_request(OP_POP,    '0,       6'd0);
      send_request(OP_ERASE,  '0,       6'd0);
      send_request(OP_INSERT, 32'sd5,   6'd1);
      send_request(OP_INSERT, WORD_MIN, 6'd0);
      send_request(OP_PUSH,   WORD_MAX, 6'd63);
      send_request(OP_PUSH,   -32'sd1,  6'd0);
      send_request(OP_PUSH,   '0,       6'd0);
      send_request(OP_INSERT, 32'sh5555_5555, 6'd1);
      send_request(OP_INSERT, 32'shaaaa_aaaa, 6'd5);
      send_request(OP_INSERT, 32'sd7,   6'd63);
      send_request(OP_ERASE,  '0,       6'd6);
      send_request(OP_ERASE,  '0,       6'd5);
      send_request(OP_ERASE,  '0,       6'd0);
      send_request(OP_ERASE,  '0,       6'd1);
      send_request(OP_DUMP,   '0,       6'd0);
      send_request(OP_SPARE_6, -32'sd1, 6'd63);
      send_request(OP_SPARE_7, '0,      6'd0);
      send_request(OP_CLEAR,  '0,       6'd0);
      send_request(OP_DUMP,   '0,       6'd0);
      send_request(OP_POP,    '0,       6'd0);
      send_request(OP_PUSH,   32'sd1,   6'd0);
      send_request(OP_DUMP,   '0,       6'd0);
      drain_responses();
   endtask

   task automatic test_full_array();
      while (shadow_count < DEPTH) begin
         send_request(OP_PUSH, $urandom, IDX_W'($urandom_range(0, 63)));
      end
      send_request(OP_PUSH,   $urandom, 6'd0);
      send_request(OP_INSERT, $urandom, IDX_W'(DEPTH));
      send_request(OP_INSERT, $urandom, 6'd0);
      send_request(OP_INSERT, $urandom, IDX_W'(DEPTH + 1));
      send_request(OP_ERASE,  '0,       IDX_W'(DEPTH));
      send_request(OP_DUMP,   '0,       6'd0);
      send_request(OP_ERASE,  '0,       IDX_W'(DEPTH - 1));
      send_request(OP_INSERT, WORD_MIN, 6'd0);
      send_request(OP_DUMP,   '0,       6'd0);
      send_request(OP_ERASE,  '0,       6'd0);
      send_request(OP_POP,    '0,       6'd0);
      send_request(OP_DUMP,   '0,       6'd0);
      send_request(OP_CLEAR,  '0,       6'd0);
      drain_responses();
   endtask

   task automatic test_random_mix(input int n_items);
      mix_phase_type            phase;
      int                       phase_left;
      int                       pick;
      logic [REQ_W-1:0]         op;
      logic signed [DATA_W-1:0] val;
      logic [IDX_W-1:0]         idx;
      phase      = PH_MIXED;
      phase_left = 0;
      for (int n = 0; n < n_items; n++) begin
         if (phase_left == 0) begin
            phase      = mix_phase_type'($urandom_range(0, 2));
            phase_left = $urandom_range(10, 40);
            gaps_on    = ($urandom_range(0, 2) != 0);
         end
         phase_left--;
         if (n == n_items / 2) drain_responses();
         pick = $urandom_range(0, 99);
         case (phase)
            PH_GROW:
               op = pick < 40 ? OP_PUSH : pick < 80 ? OP_INSERT : pick < 86 ? OP_ERASE :
                    pick < 91 ? OP_POP : pick < 97 ? OP_DUMP : pick < 98 ? OP_CLEAR :
                    pick < 99 ? OP_SPARE_6 : OP_SPARE_7;
            PH_SHRINK:
               op = pick < 10 ? OP_PUSH : pick < 20 ? OP_INSERT : pick < 58 ? OP_ERASE :
                    pick < 86 ? OP_POP : pick < 96 ? OP_DUMP : pick < 98 ? OP_CLEAR :
                    pick < 99 ? OP_SPARE_6 : OP_SPARE_7;
            default:
               op = pick < 22 ? OP_PUSH : pick < 44 ? OP_INSERT : pick < 64 ? OP_ERASE :
                    pick < 82 ? OP_POP : pick < 94 ? OP_DUMP : pick < 96 ? OP_CLEAR :
                    pick < 98 ? OP_SPARE_6 : OP_SPARE_7;
         endcase
         if ((op == OP_INSERT || op == OP_ERASE) && $urandom_range(0, 9) != 0) begin
            if (op == OP_INSERT) idx = IDX_W'($urandom_range(0, shadow_count));
            else if (shadow_count > 0) idx = IDX_W'($urandom_range(0, shadow_count - 1));
            else idx = IDX_W'($urandom_range(0, 63));
         end else begin
            idx = IDX_W'($urandom_range(0, 63));
         end
         if ($urandom_range(0, 15) == 0) val = $urandom_range(0, 1) ? WORD_MIN : WORD_MAX;
         else val = $urandom;
         send_request(op, val, idx);
      end
      gaps_on = 1'b1;
      drain_responses();
   endtask

   initial begin : stimulus
      reset           <= 1'b1;
      req_if.valid    <= 1'b0;
      req_if.req_type <= OP_PUSH;
      req_if.value    <= '0;
      req_if.index    <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed_edges();
      test_full_array();
      test_random_mix(160);
      if (error_count == 0 && expected_rsps.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
